@@ hdl/bdw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdw_pkg;

    // Configuration register layout
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int DIM_W       = 11;
    localparam int SHAPE_W     = 2;
    localparam int SIZE_W      = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SHAPE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE  = 2'd3;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [SHAPE_W-1:0] RST_WINDOW_SHAPE = 2'd0;
    localparam logic [SIZE_W-1:0]  RST_WINDOW_SIZE  = 4'd3;

    // Window shapes; any other code behaves as a square
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_HLINE  = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_VLINE  = 2'd2;

    // Item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int PIX_W = 8;
    localparam logic [PIX_W-1:0] THRESHOLD = 8'd128;
    localparam logic [PIX_W-1:0] ON_VALUE  = 8'd255;
    localparam logic [PIX_W-1:0] OFF_VALUE = 8'd0;

endpackage

`default_nettype wire

@@ hdl/bdw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/binary_dilation_window_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Binary dilation of a raster-order grey image. Each pixel item is thresholded
// (above 128 is set); each output pixel is 255 when any set pixel lies in its
// window, else 0, with coordinates clamped to the frame border. One item is
// taken per clock when the output side keeps up; a result passes through the
// input register, the line store read register and the output register after
// the item that releases it is accepted. The horizontal part of the window is
// folded in as pixels arrive, so every output needs exactly one read of the
// line stores, which hold one bit per column for each of the ring rows; that
// single read port per line store is what sets the one item per clock figure.
// The last few columns of each row are kept in a small tail register per ring
// row instead of the line stores. Flush items (tuser high) release results
// still pending after the last pixel of the frame; the result carrying tlast
// closes the frame and the next pixel starts a new one. A register write
// restarts the frame. There is no clearing pass after reset.
module binary_dilation_window_unit
    import bdw_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel_in
    input  wire logic                   s_axis_tuser,   // [0] opcode
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [PIX_W-1:0]       m_axis_tdata,   // [7:0] pixel_out
    output logic                        m_axis_tlast,   // frame_last
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int SW   = $clog2(MAX_WINDOW + 1);
    localparam int RING = 2 ** $clog2(MAX_WINDOW + 1);
    localparam int SLW  = $clog2(RING);

    // ---------------------------------------------------------------
    // Configuration registers and the derived frame/window geometry
    // ---------------------------------------------------------------
    logic [DIM_W-1:0]   r_cfg_w;
    logic [DIM_W-1:0]   r_cfg_h;
    logic [SHAPE_W-1:0] r_cfg_shape;
    logic [SIZE_W-1:0]  r_cfg_size;
    logic               cfg_wr;

    logic [CW-1:0] w;
    logic [RW-1:0] h;
    logic [SW-1:0] size, lo, hi, hlo, hhi, vlo, vhi, hspan;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= RST_IMAGE_WIDTH;
            r_cfg_h     <= RST_IMAGE_HEIGHT;
            r_cfg_shape <= RST_WINDOW_SHAPE;
            r_cfg_size  <= RST_WINDOW_SIZE;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_w     <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_h     <= i_cfg_data;
                CFG_WINDOW_SHAPE: r_cfg_shape <= i_cfg_data[SHAPE_W-1:0];
                CFG_WINDOW_SIZE:  r_cfg_size  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w = CW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h = RW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(r_cfg_h);
        end
        if (r_cfg_size == '0) begin
            size = SW'(1);
        end else if (32'(r_cfg_size) > MAX_WINDOW) begin
            size = SW'(MAX_WINDOW);
        end else begin
            size = SW'(r_cfg_size);
        end
        lo = size >> 1;
        hi = (size - SW'(1)) >> 1;
        // A vertical line has no horizontal reach, a horizontal line no vertical reach
        hlo   = (r_cfg_shape == SHAPE_VLINE) ? '0 : lo;
        hhi   = (r_cfg_shape == SHAPE_VLINE) ? '0 : hi;
        hspan = (r_cfg_shape == SHAPE_VLINE) ? SW'(1) : size;
        vlo   = (r_cfg_shape == SHAPE_HLINE) ? '0 : lo;
        vhi   = (r_cfg_shape == SHAPE_HLINE) ? '0 : hi;
    end

    // ---------------------------------------------------------------
    // Pipeline flow: input register -> result stage -> output register
    // ---------------------------------------------------------------
    logic             r_s1_valid;
    logic             r_s1_op;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s2_valid;
    logic [RW-1:0]    r_s2_row;
    logic [CW-1:0]    r_s2_col;
    logic             r_s2_last;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_last;

    logic out_free, s2_move, s1_go, in_take;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s2_move       = r_s2_valid && out_free;
    assign s1_go         = r_s1_valid && (!r_s2_valid || out_free);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // Frame position counters and row-wise horizontal dilation
    // ---------------------------------------------------------------
    logic [CW-1:0]         r_in_col, r_out_col;
    logic [RW-1:0]         r_in_row, r_out_row;
    logic [MAX_WINDOW-1:0] r_shift;
    logic [MAX_WINDOW-1:0] r_tail [RING];

    logic                  pix_take, pix_bit, row_end;
    logic [MAX_WINDOW-1:0] s_base, s_new, span_mask;
    logic                  hval;
    logic [SLW-1:0]        slot_in;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [CW-1:0]         col_inc, in_col1, oc_inc;
    logic [RW-1:0]         in_row1;
    logic [31:0]           ry, rx;
    logic                  bad, ready, emit, emit_last;

    always_comb begin
        pix_take  = (r_s1_op == OP_PIXEL) && (r_in_row < h);
        pix_bit   = r_s1_pix > THRESHOLD;
        // A fresh row starts with an empty history, which also covers the left clamp
        s_base    = (r_in_col == '0) ? '0 : r_shift;
        s_new     = (s_base << 1) | MAX_WINDOW'(pix_bit);
        span_mask = (MAX_WINDOW'(1) << hspan) - MAX_WINDOW'(1);
        hval      = |(s_new & span_mask);
        slot_in   = SLW'(r_in_row % RING);
        ram_we    = s1_go && pix_take && (32'(r_in_col) >= 32'(hhi));
        ram_waddr = AW'(32'(r_in_col) - 32'(hhi));

        col_inc = r_in_col + CW'(1);
        row_end = pix_take && (col_inc >= w);
        in_col1 = pix_take ? (row_end ? '0 : col_inc) : r_in_col;
        in_row1 = row_end ? r_in_row + RW'(1) : r_in_row;

        // Next output is released once its lower-right reach has arrived
        bad = (r_out_row >= h) || (r_out_col >= w);
        ry  = 32'(r_out_row) + 32'(hi);
        if (ry > 32'(h) - 32'd1) begin
            ry = 32'(h) - 32'd1;
        end
        rx  = 32'(r_out_col) + 32'(hi);
        if (rx > 32'(w) - 32'd1) begin
            rx = 32'(w) - 32'd1;
        end
        ready = (in_row1 >= h) || (ry < 32'(in_row1))
             || ((ry == 32'(in_row1)) && (rx < 32'(in_col1)));
        emit      = !bad && ready;
        emit_last = (r_out_row == h - RW'(1)) && (r_out_col == w - CW'(1));
        oc_inc    = r_out_col + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_wr) begin
            // Any register write abandons the frame in progress
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (s1_go) begin
            if (bad || (emit && emit_last)) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col <= in_col1;
                r_in_row <= in_row1;
                if (emit) begin
                    if (oc_inc >= w) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + RW'(1);
                    end else begin
                        r_out_col <= oc_inc;
                    end
                end
            end
        end
    end

    // Hold the recent pixels of the row; snapshot them into the tail at row end
    always_ff @(posedge i_clk) begin
        if (s1_go && pix_take) begin
            r_shift <= s_new;
            if (row_end) begin
                r_tail[slot_in] <= s_new;
            end
        end
    end

    // ---------------------------------------------------------------
    // Line stores: one bit per column for every ring row
    // ---------------------------------------------------------------
    logic [RING-1:0] ram_q;

    for (genvar g = 0; g < RING; g++) begin : g_line
        bdw_ram #(
            .WIDTH (1),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (ram_we && (slot_in == SLW'(g))),
            .i_waddr (ram_waddr),
            .i_wdata (hval),
            .i_re    (s1_go),
            .i_raddr (AW'(r_out_col)),
            .o_rdata (ram_q[g])
        );
    end

    // Write of the same item, forwarded past the read-before-write line store
    logic           r_fw_we;
    logic [SLW-1:0] r_fw_slot;
    logic [AW-1:0]  r_fw_addr;
    logic           r_fw_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fw_we    <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_s2_valid <= emit && !cfg_wr;
                r_fw_we    <= ram_we;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op  <= s_axis_tuser;
            r_s1_pix <= s_axis_tdata;
        end
        if (s1_go) begin
            r_s2_row  <= r_out_row;
            r_s2_col  <= r_out_col;
            r_s2_last <= emit_last;
            r_fw_slot <= slot_in;
            r_fw_addr <= ram_waddr;
            r_fw_data <= hval;
        end
    end

    // ---------------------------------------------------------------
    // Result stage: vertical OR over the clamped ring rows
    // ---------------------------------------------------------------
    logic [RING-1:0]       col_q, hbit, v_mask;
    logic                  tail_sel, hit;
    logic [31:0]           tail_top;
    logic [MAX_WINDOW-1:0] tail_mask;

    always_comb begin
        tail_sel  = (32'(r_s2_col) + 32'(hhi)) >= 32'(w);
        tail_top  = 32'(w) - 32'd1 - 32'(r_s2_col) + 32'(hlo);
        tail_mask = (MAX_WINDOW'(1) << (tail_top + 32'd1)) - MAX_WINDOW'(1);
        for (int s = 0; s < RING; s++) begin
            col_q[s] = ram_q[s];
            if (r_fw_we && (r_fw_slot == SLW'(s)) && (r_fw_addr == AW'(r_s2_col))) begin
                col_q[s] = r_fw_data;
            end
            hbit[s] = tail_sel ? |(r_tail[s] & tail_mask) : col_q[s];
        end
    end

    always_comb begin
        int yy;
        v_mask = '0;
        yy     = 0;
        for (int d = 0; d < MAX_WINDOW; d++) begin
            yy = int'(r_s2_row) + d - int'(vlo);
            if (yy < 0) begin
                yy = 0;
            end
            if (yy > int'(h) - 1) begin
                yy = int'(h) - 1;
            end
            if (d <= int'(vlo) + int'(vhi)) begin
                v_mask[SLW'(yy % RING)] = 1'b1;
            end
        end
    end

    assign hit = |(v_mask & hbit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_pix  <= hit ? ON_VALUE : OFF_VALUE;
            r_out_last <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_last;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_in_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col < w)
        else $error("input column outside the row");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && emit && emit_last)
        |=> (r_out_row == '0 && r_out_col == '0 && r_in_row == '0 && r_in_col == '0))
        else $error("counters not cleared after the last result of a frame");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_out_valid && !m_axis_tready) |=> r_s2_valid)
        else $error("pending result lost while the output stalls");

    a_result_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_s2_col < w && r_s2_row < h))
        else $error("result position outside the frame");

endmodule

`default_nettype wire
